@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of the liveness monitor.
// Each macro expects a clock and an active-low reset from the caller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HLM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/hlm_pkg.sv @@
// Shared types and codes of the heartbeat liveness monitor.
// No dependencies; used by the top level and the checker.
package hlm_pkg;

	// Input item modes
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_PONG   = 2'd2;
	localparam logic [1:0] MODE_TICK   = 2'd3;

	// Result event codes
	localparam logic [1:0] EV_PING     = 2'd0;
	localparam logic [1:0] EV_DOWN     = 2'd1;
	localparam logic [1:0] EV_RESTORED = 2'd2;
	localparam logic [1:0] EV_FULL     = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_FAILURE_LIMIT = 2'd0;
	localparam logic [1:0] CFG_PING_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_CHECK_PERIOD  = 2'd2;

	localparam logic [3:0] MISS_MAX  = 4'd15;
	localparam logic [7:0] TICK_MAX  = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PROC,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		OP_FIND,
		OP_CHECK,
		OP_RESTORE,
		OP_PING
	} op_t;

	typedef struct packed {
		logic [31:0] address;
		logic [15:0] port;
		logic        pong;
		logic [3:0]  miss;
		logic        down;
	} entry_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] peer_address;
		logic [15:0] peer_port;
		logic        last;
	} result_t;

endpackage

@@ sv/hlm_intf.sv @@
// Channel interfaces of the heartbeat liveness monitor: command, event and
// configuration write. Valid/ready handshake; depends on nothing else.
interface hlm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] endpoint_address;
	logic [15:0] endpoint_port;

	modport source (output valid, mode, endpoint_address, endpoint_port, input ready);
	modport sink   (input valid, mode, endpoint_address, endpoint_port, output ready);
endinterface

interface hlm_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [31:0] peer_address;
	logic [15:0] peer_port;
	logic        last;

	modport source (output valid, event_res, peer_address, peer_port, last, input ready);
	modport sink   (input valid, event_res, peer_address, peer_port, last, output ready);
endinterface

interface hlm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] addr;
	logic [7:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

@@ sv/heartbeat_liveness_monitor.sv @@
// Heartbeat liveness monitor: peer table in one synchronous memory plus a
// slot-walking sequencer. Depends on hlm_pkg and the channel interfaces.
//
// cmd carries one word per item: add, remove, pong (keyed by IPv4 address and
// UDP port) or a 100 ms tick. cmd.ready is high only while the sequencer is
// idle, so one item is worked on at a time. evt carries result words; last
// marks the final word of an item. cfg writes failure_limit (0), ping_period
// (1) and check_period (2); it is always ready and is meant for idle times.
// Each item walks the table from slot 0: a slot with nothing to do is skipped
// in ST_READ, any other is read in ST_READ (memory read), then modified and
// written back in ST_PROC, as the table read is registered. Add, remove and
// pong walk the table once and stop early on a match; a ping round takes one walk,
// a check two (update, then restored reports). A tick that starts no round
// only advances the tick counters. Add to a full table, and any round with
// reports, end in ST_FLUSH, which releases the final word.
// Reset frees all slots, zeroes the tick counters and loads 4 / 5 / 10.
// When evt stalls, results back up through a hold stage and an output
// register, then the walk holds on the slot that needs to report.
module heartbeat_liveness_monitor #(
	parameter int TABLE_SIZE = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	hlm_cfg_if.sink   cfg,
	hlm_cmd_if.sink   cmd,
	hlm_evt_if.source evt
);

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

	// Control state
	hlm_pkg::state_t          state_q, state_d;
	hlm_pkg::op_t             op_q, op_d;
	logic [IDX_W-1:0]         idx_q, idx_d;
	logic [TABLE_SIZE-1:0]    valid_q;   // slot occupied
	logic [TABLE_SIZE-1:0]    back_q;    // slot came back during this check
	logic [3:0]               limit_q;
	logic [7:0]               ping_per_q;
	logic [7:0]               check_per_q;
	logic [7:0]               tsp_q;
	logic [7:0]               tsc_q;
	logic                     hold_v_q;
	logic                     out_v_q;

	// Payload registers
	logic [1:0]               mode_q;
	logic [31:0]              addr_q;
	logic [15:0]              port_q;
	hlm_pkg::result_t         hold_q;
	hlm_pkg::result_t         out_q;

	// Peer table memory and its registered read data
	hlm_pkg::entry_t          mem_q [TABLE_SIZE];
	hlm_pkg::entry_t          rdata_q;

	// Handshakes
	logic cmd_acc;
	logic cfg_acc;
	logic out_free;

	assign cmd.ready = (state_q == hlm_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign out_free  = !out_v_q || evt.ready;

	assign evt.valid        = out_v_q;
	assign evt.event_res    = out_q.event_res;
	assign evt.peer_address = out_q.peer_address;
	assign evt.peer_port    = out_q.peer_port;
	assign evt.last         = out_q.last;

	// Lowest free slot for an add
	logic             free_found;
	logic [IDX_W-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Tick counters, saturating; a check wins over a ping round
	logic [7:0] tsp_inc;
	logic [7:0] tsc_inc;
	logic       do_check;
	logic       do_ping;

	always_comb begin
		tsp_inc  = (tsp_q == hlm_pkg::TICK_MAX) ? tsp_q : tsp_q + 8'd1;
		tsc_inc  = (tsc_q == hlm_pkg::TICK_MAX) ? tsc_q : tsc_q + 8'd1;
		do_check = (tsc_inc >= check_per_q);
		do_ping  = !do_check && (tsp_inc >= ping_per_q);
	end

	// Slot decode and the per-slot modify step on the read data
	logic             visit;
	logic             is_last_idx;
	logic             match;
	logic             emit;
	logic             slot_back;
	logic             can_push;
	logic             proc_go;
	logic             stop_find;
	logic             adv;
	logic             pass_end;
	logic             add_full;
	logic [3:0]       miss_inc;
	hlm_pkg::entry_t  ent_new;
	hlm_pkg::result_t res_new;

	always_comb begin
		visit       = valid_q[idx_q] && (op_q != hlm_pkg::OP_RESTORE || back_q[idx_q]);
		is_last_idx = (idx_q == IDX_LAST);
		match       = (rdata_q.address == addr_q) && (rdata_q.port == port_q);
		miss_inc    = (rdata_q.miss == hlm_pkg::MISS_MAX) ? rdata_q.miss
		                                                  : rdata_q.miss + 4'd1;
		ent_new     = rdata_q;
		emit        = 1'b0;
		slot_back   = 1'b0;
		res_new.event_res    = hlm_pkg::EV_PING;
		res_new.peer_address = rdata_q.address;
		res_new.peer_port    = rdata_q.port;
		res_new.last         = 1'b0;

		case (op_q)
			hlm_pkg::OP_FIND: begin
				if (mode_q == hlm_pkg::MODE_PONG)
					ent_new.pong = 1'b1;
			end
			hlm_pkg::OP_CHECK: begin
				if (rdata_q.pong) begin
					ent_new.miss = '0;
					ent_new.pong = 1'b0;
					ent_new.down = 1'b0;
					slot_back    = rdata_q.down;
				end else begin
					ent_new.miss = miss_inc;
					if (miss_inc >= limit_q) begin
						ent_new.down = 1'b1;
						emit         = !rdata_q.down;
					end
				end
				res_new.event_res = hlm_pkg::EV_DOWN;
			end
			hlm_pkg::OP_RESTORE: begin
				emit              = 1'b1;
				res_new.event_res = hlm_pkg::EV_RESTORED;
			end
			hlm_pkg::OP_PING: begin
				ent_new.pong = 1'b0;
				emit         = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		// A new word may enter the hold stage if the hold stage is empty or can spill
		can_push  = !hold_v_q || out_free;
		proc_go   = (state_q == hlm_pkg::ST_PROC) && (!emit || can_push);
		stop_find = proc_go && (op_q == hlm_pkg::OP_FIND) && match;
		adv       = ((state_q == hlm_pkg::ST_READ) && !visit) || (proc_go && !stop_find);
		pass_end  = adv && is_last_idx;
		add_full  = pass_end && (op_q == hlm_pkg::OP_FIND)
		            && (mode_q == hlm_pkg::MODE_ADD) && !free_found;
	end

	// Datapath controls
	logic             rd_en;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	hlm_pkg::entry_t  wr_data;
	logic             set_valid;
	logic             clr_valid;
	logic             set_back;
	logic             push;
	hlm_pkg::result_t push_res;
	hlm_pkg::result_t flush_res;
	logic             flush;

	always_comb begin
		rd_en     = (state_q == hlm_pkg::ST_READ) && visit;
		wr_en     = 1'b0;
		wr_idx    = idx_q;
		wr_data   = ent_new;
		set_valid = 1'b0;
		clr_valid = stop_find && (mode_q == hlm_pkg::MODE_REMOVE);
		set_back  = proc_go && (op_q == hlm_pkg::OP_CHECK) && slot_back;
		push      = proc_go && emit;
		push_res  = res_new;
		flush     = (state_q == hlm_pkg::ST_FLUSH) && out_free;

		// The final word of an item leaves the hold stage marked last
		flush_res      = hold_q;
		flush_res.last = 1'b1;

		if (proc_go && (op_q == hlm_pkg::OP_CHECK || op_q == hlm_pkg::OP_PING))
			wr_en = 1'b1;
		if (stop_find && mode_q == hlm_pkg::MODE_PONG)
			wr_en = 1'b1;

		// Add of an unknown peer: fill the lowest free slot after the walk
		if (pass_end && op_q == hlm_pkg::OP_FIND && mode_q == hlm_pkg::MODE_ADD
		    && free_found) begin
			wr_en           = 1'b1;
			wr_idx          = free_idx;
			wr_data.address = addr_q;
			wr_data.port    = port_q;
			wr_data.pong    = 1'b0;
			wr_data.miss    = '0;
			wr_data.down    = 1'b0;
			set_valid       = 1'b1;
		end

		if (add_full) begin
			push                  = 1'b1;
			push_res.event_res    = hlm_pkg::EV_FULL;
			push_res.peer_address = addr_q;
			push_res.peer_port    = port_q;
			push_res.last         = 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		idx_d   = idx_q;

		case (state_q)
			hlm_pkg::ST_IDLE: begin
				if (cmd_acc) begin
					idx_d = '0;
					if (cmd.mode != hlm_pkg::MODE_TICK) begin
						state_d = hlm_pkg::ST_READ;
						op_d    = hlm_pkg::OP_FIND;
					end else if (do_check) begin
						state_d = hlm_pkg::ST_READ;
						op_d    = hlm_pkg::OP_CHECK;
					end else if (do_ping) begin
						state_d = hlm_pkg::ST_READ;
						op_d    = hlm_pkg::OP_PING;
					end
				end
			end
			hlm_pkg::ST_READ, hlm_pkg::ST_PROC: begin
				if (stop_find) begin
					state_d = hlm_pkg::ST_IDLE;
				end else if (pass_end) begin
					case (op_q)
						hlm_pkg::OP_FIND: begin
							state_d = add_full ? hlm_pkg::ST_FLUSH : hlm_pkg::ST_IDLE;
						end
						hlm_pkg::OP_CHECK: begin
							state_d = hlm_pkg::ST_READ;
							op_d    = hlm_pkg::OP_RESTORE;
							idx_d   = '0;
						end
						default: begin
							state_d = (push || hold_v_q) ? hlm_pkg::ST_FLUSH
							                             : hlm_pkg::ST_IDLE;
						end
					endcase
				end else if (adv) begin
					state_d = hlm_pkg::ST_READ;
					idx_d   = idx_q + 1'b1;
				end else if (rd_en) begin
					state_d = hlm_pkg::ST_PROC;
				end
			end
			hlm_pkg::ST_FLUSH: begin
				if (out_free)
					state_d = hlm_pkg::ST_IDLE;
			end
			default: begin
				state_d = hlm_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hlm_pkg::ST_IDLE;
			op_q        <= hlm_pkg::OP_FIND;
			idx_q       <= '0;
			valid_q     <= '0;
			back_q      <= '0;
			limit_q     <= 4'd4;
			ping_per_q  <= 8'd5;
			check_per_q <= 8'd10;
			tsp_q       <= '0;
			tsc_q       <= '0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			idx_q   <= idx_d;

			if (cfg_acc) begin
				case (cfg.addr)
					hlm_pkg::CFG_FAILURE_LIMIT: limit_q     <= cfg.data[3:0];
					hlm_pkg::CFG_PING_PERIOD:   ping_per_q  <= cfg.data;
					hlm_pkg::CFG_CHECK_PERIOD:  check_per_q <= cfg.data;
					default: ;
				endcase
			end

			// Advance tick counters; a check restarts both, a ping round only the ping counter
			if (cmd_acc && cmd.mode == hlm_pkg::MODE_TICK) begin
				if (do_check) begin
					tsp_q  <= '0;
					tsc_q  <= '0;
					back_q <= '0;
				end else if (do_ping) begin
					tsp_q <= '0;
					tsc_q <= tsc_inc;
				end else begin
					tsp_q <= tsp_inc;
					tsc_q <= tsc_inc;
				end
			end

			if (set_valid)
				valid_q[wr_idx] <= 1'b1;
			if (clr_valid)
				valid_q[idx_q] <= 1'b0;
			if (set_back)
				back_q[idx_q] <= 1'b1;

			// Hold stage and output register
			if (push)
				hold_v_q <= 1'b1;
			else if (flush)
				hold_v_q <= 1'b0;

			if ((push && hold_v_q) || flush)
				out_v_q <= 1'b1;
			else if (evt.ready)
				out_v_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			mode_q <= cmd.mode;
			addr_q <= cmd.endpoint_address;
			port_q <= cmd.endpoint_port;
		end
		if (push) begin
			hold_q <= push_res;
			if (hold_v_q)
				out_q <= hold_q;
		end else if (flush) begin
			out_q <= flush_res;
		end
	end

	// Peer table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= wr_data;
		if (rd_en)
			rdata_q <= mem_q[idx_q];
	end

endmodule

@@ sv/hlm_checker.sv @@
// Port-level checker of the heartbeat liveness monitor, bound to the top.
// Depends on hlm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hlm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  cmd_mode,
	input logic        evt_valid,
	input logic        evt_ready,
	input logic [1:0]  evt_event_res,
	input logic [31:0] evt_peer_address,
	input logic [15:0] evt_peer_port,
	input logic        evt_last
);

	// Hold a stalled word
	`HLM_ASSERT_NXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable(evt_peer_address) && $stable(evt_peer_port) && $stable(evt_event_res) && $stable(evt_last), "event word changed while stalled")

	// Table keeping items always walk the table, so the block is busy next
	`HLM_ASSERT_NXT(a_busy_walk, clk, arst_n, cmd_valid && cmd_ready && cmd_mode != hlm_pkg::MODE_TICK, !cmd_ready, "command taken during table walk")

	// An item is not taken while an earlier item still has words to come
	`HLM_ASSERT_NOW(a_no_overlap, clk, arst_n, evt_valid && !evt_last, !cmd_ready, "command ready in the middle of a burst")

	// Table full is always the only word of its item
	`HLM_ASSERT_NOW(a_full_alone, clk, arst_n, evt_valid && evt_event_res == hlm_pkg::EV_FULL, evt_last, "table full word not marked last")

endmodule

bind heartbeat_liveness_monitor hlm_checker u_hlm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_mode         (cmd.mode),
	.evt_valid        (evt.valid),
	.evt_ready        (evt.ready),
	.evt_event_res    (evt.event_res),
	.evt_peer_address (evt.peer_address),
	.evt_peer_port    (evt.peer_port),
	.evt_last         (evt.last)
);
